FILE: rtl/core/assert_macros.svh
// Assertion helpers for the tone-mapping block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HHTM_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("hhtm check failed");

// Checked on every rising edge, reset included.
`define HHTM_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("hhtm check failed");

`endif

FILE: rtl/core/hhtm_pkg.sv
// ----------------------------------------------------------------------------
// hhtm_pkg
// Constants, table builders and shared helpers for the HDR tone mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package hhtm_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int APPROX_TABLE_BITS = 6;
  localparam int TAB_N             = 1 << APPROX_TABLE_BITS;
  localparam int RB                = FRAC_BITS - APPROX_TABLE_BITS;

  // datapath widths
  localparam int XW  = FRAC_BITS + 19;   // exposed value
  localparam int YW  = FRAC_BITS + 17;   // knee argument
  localparam int KW  = FRAC_BITS + 6;    // knee output
  localparam int LYW = FRAC_BITS + 5;    // log2 of knee argument
  localparam int LKW = FRAC_BITS + 7;    // signed log2 of knee output
  localparam int RW  = FRAC_BITS + 2;    // table word
  localparam int VW  = RW + 31;          // scaled exp2 before shift
  localparam int PW  = 6;                // bit position

  localparam int NSTAGE = 13;

  // Q16 constants
  localparam int K_EXPOSE   = 364088;
  localparam int K_KNEE     = 12116;
  localparam int K_KNEE_INV = 245714;
  localparam int K_GAMMA    = 29786;
  localparam int K_SCALE    = 5548278;

  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;

  typedef logic [RW-1:0] rom_t [TAB_N+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v0;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] q30_to_qf(input logic [63:0] r);
    return (r + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  // log2(1+i/N) or 2^(i/N), derived in Q30 and rounded to Q.F
  function automatic rom_t build_rom(input logic is_exp);
    logic [63:0] root [APPROX_TABLE_BITS+1];
    logic [63:0] z;
    logic [63:0] r;
    logic [63:0] e;
    rom_t        t;
    root[0] = 64'd2 << 30;
    for (int k = 1; k <= APPROX_TABLE_BITS; k++) root[k] = isqrt64(root[k-1] << 30);
    for (int i = 0; i < TAB_N; i++) begin
      z = (64'd1 << 30) + (64'(i) << (30 - APPROX_TABLE_BITS));
      r = '0;
      e = 64'd1 << 30;
      for (int k = 1; k <= 30; k++) begin
        z = (z * z) >> 30;
        if (z >= (64'd2 << 30)) begin
          z = z >> 1;
          r = r | (64'd1 << (30 - k));
        end
      end
      for (int k = 0; k < APPROX_TABLE_BITS; k++)
        if (((i >> k) & 1) != 0) e = (e * root[APPROX_TABLE_BITS - k]) >> 30;
      t[i] = is_exp ? RW'(q30_to_qf(e)) : RW'(q30_to_qf(r));
    end
    t[TAB_N] = is_exp ? (RW'(2) << FRAC_BITS) : (RW'(1) << FRAC_BITS);
    return t;
  endfunction

  localparam rom_t LOG_ROM = build_rom(1'b0);
  localparam rom_t EXP_ROM = build_rom(1'b1);

  function automatic logic [PW-1:0] lead_one(input logic [XW-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < XW; i++)
      if (v[i]) p = PW'(i);
    return p;
  endfunction

  // fraction bits of v normalised so that its leading one sits at bit FRAC_BITS
  function automatic logic [FRAC_BITS-1:0] norm_frac(input logic [XW-1:0] v,
                                                     input logic [PW-1:0] p);
    logic [XW+FRAC_BITS-1:0] w;
    w = {v, {FRAC_BITS{1'b0}}} >> p;
    return w[FRAC_BITS-1:0];
  endfunction

  function automatic logic [RW-1:0] rom_lookup(input rom_t rom,
                                               input logic [FRAC_BITS-1:0] frac);
    logic [APPROX_TABLE_BITS:0] idx;
    logic [RB-1:0]              rem;
    logic [RW-1:0]              d;
    logic [RW+RB-1:0]           pr;
    idx = {1'b0, frac[FRAC_BITS-1:RB]};
    rem = frac[RB-1:0];
    d   = rom[idx + 1'b1] - rom[idx];
    pr  = (RW+RB)'(d) * (RW+RB)'(rem);
    return rom[idx] + RW'(pr >> RB);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hhtm_lane.sv
// ----------------------------------------------------------------------------
// hhtm_lane
// One channel of the tone curve: half float in, display byte out, 13 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hhtm_lane (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [15:0] half_in,
  output logic [7:0]      byte_out
);

  localparam int F = hhtm_pkg::FRAC_BITS;
  localparam int SPN = hhtm_pkg::NSTAGE - 1;

  // forced results travel beside the arithmetic
  logic [SPN-1:0] sp;
  logic [7:0]     spv [SPN];

  logic [29:0]                    r1_prod;
  logic signed [6:0]              r1_sh;
  logic [hhtm_pkg::KW-1:0]        r2_x, r3_x, r4_x, r5_x, r6_x;
  logic                           r2_big, r3_big, r4_big, r5_big, r6_big;
  logic [hhtm_pkg::XW+13:0]       r2_pk;
  logic [hhtm_pkg::YW-1:0]        r3_y;
  logic [hhtm_pkg::PW-1:0]        r3_p, r4_p, r7_p, r8_p;
  logic [F-1:0]                   r4_f, r8_f;
  logic [hhtm_pkg::LYW-1:0]       r5_ly;
  logic [hhtm_pkg::LYW+17:0]      r6_pk;
  logic [hhtm_pkg::KW-1:0]        r7_k;
  logic signed [hhtm_pkg::LKW-1:0] r9_lk;
  logic [hhtm_pkg::LKW+14:0]      r10_mag;
  logic                           r10_neg;
  logic [hhtm_pkg::RW-1:0]        r11_e;
  logic signed [6:0]              r11_n, r12_n;
  logic [hhtm_pkg::VW-1:0]        r12_v;

  // stage 1: decode
  logic       s1_sgn;
  logic [4:0] s1_e, s1_ex;
  logic [9:0] s1_m;
  logic [10:0] s1_mant;
  logic       s1_sp;
  logic [7:0] s1_spv;

  always_comb begin
    s1_sgn  = half_in[15];
    s1_e    = half_in[14:10];
    s1_m    = half_in[9:0];
    s1_sp   = (s1_e == 5'd31) | s1_sgn | ((s1_e == 5'd0) & (s1_m == 10'd0));
    s1_spv  = ((s1_e == 5'd31) & (s1_m == 10'd0) & !s1_sgn) ? 8'd255 : 8'd0;
    s1_ex   = (s1_e == 5'd0) ? 5'd1 : s1_e;
    s1_mant = {(s1_e != 5'd0), s1_m};
  end

  // stage 2: exposure shift and knee multiply
  logic [hhtm_pkg::XW-1:0]    s2_x, s2_diff;
  logic                       s2_zero, s2_big;
  logic [hhtm_pkg::XW+13:0]   s2_pk;

  always_comb begin
    if (r1_sh[6]) s2_x = hhtm_pkg::XW'(r1_prod) >> 7'(-r1_sh);
    else          s2_x = hhtm_pkg::XW'(r1_prod) << r1_sh;
    s2_zero = (s2_x == '0);
    s2_big  = (s2_x > hhtm_pkg::ONE_X);
    s2_diff = s2_big ? (s2_x - hhtm_pkg::ONE_X) : '0;
    s2_pk   = (hhtm_pkg::XW+14)'(s2_diff) * (hhtm_pkg::XW+14)'(hhtm_pkg::K_KNEE);
  end

  // stage 3: knee argument and its leading one
  logic [hhtm_pkg::YW-1:0] s3_y;
  always_comb
    s3_y = hhtm_pkg::YW'(hhtm_pkg::ONE_X) + hhtm_pkg::YW'(r2_pk >> 16);

  // stage 7: knee output
  logic [hhtm_pkg::KW-1:0] s7_k;
  always_comb
    s7_k = r6_big ? (hhtm_pkg::KW'(hhtm_pkg::ONE_X) + hhtm_pkg::KW'(r6_pk >> 16)) : r6_x;

  // stage 9: signed log2 of knee output
  logic signed [hhtm_pkg::LKW-1:0] s9_ip, s9_lk;
  always_comb begin
    s9_ip = $signed({{(hhtm_pkg::LKW-hhtm_pkg::PW){1'b0}}, r8_p})
            - $signed(hhtm_pkg::LKW'(F));
    s9_lk = (s9_ip <<< F)
            + $signed(hhtm_pkg::LKW'(hhtm_pkg::rom_lookup(hhtm_pkg::LOG_ROM, r8_f)));
  end

  // stage 10: gamma multiply on the magnitude
  logic                      s10_neg;
  logic [hhtm_pkg::LKW-1:0]  s10_abs;
  always_comb begin
    s10_neg = r9_lk[hhtm_pkg::LKW-1];
    s10_abs = s10_neg ? hhtm_pkg::LKW'(-r9_lk) : hhtm_pkg::LKW'(r9_lk);
  end

  // stage 11: negative gamma rounds towards minus infinity
  logic [hhtm_pkg::LKW+15:0]       s11_sum;
  logic [hhtm_pkg::LKW-1:0]        s11_gm;
  logic signed [hhtm_pkg::LKW-1:0] s11_g;
  always_comb begin
    s11_sum = r10_neg ? ({1'b0, r10_mag} + (hhtm_pkg::LKW+16)'(16'hFFFF)) : {1'b0, r10_mag};
    s11_gm  = hhtm_pkg::LKW'(s11_sum >> 16);
    s11_g   = r10_neg ? -$signed(s11_gm) : $signed(s11_gm);
  end

  // stage 13: exponent shift and saturation
  logic [hhtm_pkg::VW-1:0] s13_sv, s13_q;
  logic [7:0]              s13_byte;
  always_comb begin
    s13_sv = '0;
    if (r12_n > 7'sd8) begin
      s13_q = '1;
    end else begin
      if (!r12_n[6])              s13_sv = r12_v << r12_n;
      else if (r12_n > -7'sd63)   s13_sv = r12_v >> 7'(-r12_n);
      s13_q = s13_sv >> (F + 16);
    end
    s13_byte = (s13_q > hhtm_pkg::VW'(255)) ? 8'd255 : s13_q[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_prod <= {19'd0, s1_mant} * 30'(hhtm_pkg::K_EXPOSE);
      r1_sh   <= $signed({2'b00, s1_ex}) + 7'(F - 41);
      sp[0]   <= s1_sp;
      spv[0]  <= s1_spv;

      r2_x    <= s2_x[hhtm_pkg::KW-1:0];
      r2_big  <= s2_big;
      r2_pk   <= s2_pk;
      sp[1]   <= sp[0] | s2_zero;
      spv[1]  <= sp[0] ? spv[0] : 8'd0;

      r3_y    <= s3_y;
      r3_p    <= hhtm_pkg::lead_one(hhtm_pkg::XW'(s3_y));
      r3_x    <= r2_x;
      r3_big  <= r2_big;

      r4_f    <= hhtm_pkg::norm_frac(hhtm_pkg::XW'(r3_y), r3_p);
      r4_p    <= r3_p;
      r4_x    <= r3_x;
      r4_big  <= r3_big;

      r5_ly   <= (hhtm_pkg::LYW'(r4_p - hhtm_pkg::PW'(F)) << F)
                 + hhtm_pkg::LYW'(hhtm_pkg::rom_lookup(hhtm_pkg::LOG_ROM, r4_f));
      r5_x    <= r4_x;
      r5_big  <= r4_big;

      r6_pk   <= (hhtm_pkg::LYW+18)'(r5_ly) * (hhtm_pkg::LYW+18)'(hhtm_pkg::K_KNEE_INV);
      r6_x    <= r5_x;
      r6_big  <= r5_big;

      r7_k    <= s7_k;
      r7_p    <= hhtm_pkg::lead_one(hhtm_pkg::XW'(s7_k));

      r8_f    <= hhtm_pkg::norm_frac(hhtm_pkg::XW'(r7_k), r7_p);
      r8_p    <= r7_p;

      r9_lk   <= s9_lk;

      r10_mag <= (hhtm_pkg::LKW+15)'(s10_abs) * (hhtm_pkg::LKW+15)'(hhtm_pkg::K_GAMMA);
      r10_neg <= s10_neg;

      r11_e   <= hhtm_pkg::rom_lookup(hhtm_pkg::EXP_ROM, s11_g[F-1:0]);
      r11_n   <= s11_g[hhtm_pkg::LKW-1:F];

      r12_v   <= hhtm_pkg::VW'((hhtm_pkg::RW+23)'(r11_e)
                               * (hhtm_pkg::RW+23)'(hhtm_pkg::K_SCALE));
      r12_n   <= r11_n;

      for (int i = 2; i < SPN; i++) begin
        sp[i]  <= sp[i-1];
        spv[i] <= spv[i-1];
      end

      byte_out <= sp[SPN-1] ? spv[SPN-1] : s13_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hdr_half_tone_map_top.sv
// ----------------------------------------------------------------------------
// hdr_half_tone_map_top
// HDR pixel tone mapper: four half-float channels to four display bytes.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)
//  s_axis    in   red_half, green_half, blue_half, alpha_half (16 b each)
//  m_axis    out  red_byte, green_byte, blue_byte, alpha_byte (8 b each)
//
//  One pixel per cycle while the result is not stalled; each channel has its own pipeline.
//  All stages advance together; a stalled result freezes the whole pipe,
//  and s_tready follows the output register being free or taken.
//  Synchronous reset clears the valid line only; tables are constants.
`default_nettype none

module hdr_half_tone_map_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // red_half, green_half, blue_half, alpha_half
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // red_byte, green_byte, blue_byte, alpha_byte
);

  logic [hhtm_pkg::NSTAGE-1:0] vld;
  logic                        en;

  assign en       = !vld[hhtm_pkg::NSTAGE-1] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[hhtm_pkg::NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[hhtm_pkg::NSTAGE-2:0], s_tvalid};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    hhtm_lane u_lane (
      .clk     (clk),
      .en      (en),
      .half_in (s_tdata[16*i +: 16]),
      .byte_out(m_tdata[8*i +: 8])
    );
  end

endmodule

`default_nettype wire

FILE: rtl/core/hhtm_checker.sv
// ----------------------------------------------------------------------------
// hhtm_checker
// Port-level checks on the tone mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hhtm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // a stalled result keeps its bytes
  `HHTM_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // with the output side draining, an input request is never refused
  `HHTM_ASSERT(a_flow, clk, rst, s_tvalid && m_tready |-> s_tready)

  // nothing emerges straight after reset
  `HHTM_ASSERT_ALWAYS(a_rst, clk, $past(rst) |-> !m_tvalid)

endmodule

bind hdr_half_tone_map_top hhtm_checker u_hhtm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hdr_half_tone_map_top: a directed table of corner
// pixels, then random ones, streamed in under several idling patterns. Rows
// with listed bytes are checked against them, all others against a fixed-point
// tone curve computed here, log2/exp2 tables rebuilt from first principles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int NRAND    = 700;
  localparam int FRAC     = 16;
  localparam int TBITS    = 6;
  localparam int TSIZE    = 1 << TBITS;
  localparam int IBITS    = FRAC - TBITS;
  localparam logic [63:0] ONE = 64'd1 << FRAC;

  typedef struct {
    logic [63:0] pixel;
    bit          typed;
    logic [31:0] want;
  } pixel_row_t;

  typedef struct {
    bit          typed;
    logic [31:0] want;
  } row_tag_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;    // red_half, green_half, blue_half, alpha_half
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // red_byte, green_byte, blue_byte, alpha_byte

  logic [63:0] log_tab [TSIZE+1];
  logic [63:0] exp_tab [TSIZE+1];

  logic [31:0] byte_q [$];
  row_tag_t    tag_q [$];
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  bit          hold_req;
  int          hold_left;
  bit          stim_done;

  hdr_half_tone_map_top dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  function automatic logic [63:0] int_sqrt(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v0;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] interp(input bit use_exp, input logic [63:0] frac);
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] hi;
    idx = (frac >> IBITS) & (TSIZE - 1);
    rem = frac & ((64'd1 << IBITS) - 1);
    lo  = use_exp ? exp_tab[idx] : log_tab[idx];
    hi  = use_exp ? exp_tab[idx+1] : log_tab[idx+1];
    return lo + (((hi - lo) * rem) >> IBITS);
  endfunction

  function automatic longint log2_fixed(input logic [63:0] v);
    int          p;
    int          sh;
    logic [63:0] norm;
    p = 63;
    while (p > 0 && v[p] == 1'b0) p--;
    sh   = p - FRAC;
    norm = (sh >= 0) ? (v >> sh) : (v << (-sh));
    return longint'(sh) * longint'(ONE) + longint'(interp(1'b0, norm - ONE));
  endfunction

  function automatic logic [7:0] tone_byte(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [63:0] sig;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] k;
    logic [63:0] v;
    logic [63:0] mag;
    int          sh;
    longint      lk;
    longint      g;
    longint      n;
    e = h[14:10];
    m = h[9:0];
    if (e == 5'd31) return (m == 0 && !h[15]) ? 8'd255 : 8'd0;
    if (h[15] || (e == 0 && m == 0)) return 8'd0;
    sig = (e == 0) ? 64'(m) : 64'(m) | 64'd1024;
    sh  = ((e == 0) ? 1 : int'(e)) - 41 + FRAC;
    x   = sig * 64'd364088;
    x   = (sh >= 0) ? (x << sh) : (x >> (-sh));
    if (x == 0) return 8'd0;
    if (x > ONE) begin
      // logarithmic knee above unity
      y = ONE + (((x - ONE) * 64'd12116) >> 16);
      k = ONE + ((64'(log2_fixed(y)) * 64'd245714) >> 16);
    end else begin
      k = x;
    end
    lk = log2_fixed(k);
    if (lk >= 0) begin
      g = longint'((64'(lk) * 64'd29786) >> 16);
    end else begin
      mag = 64'(-lk) * 64'd29786;
      g   = -longint'((mag + 64'hFFFF) >> 16);
    end
    if (g >= 0) n = longint'(64'(g) >> FRAC);
    else n = -longint'((64'(-g) + ONE - 1) >> FRAC);
    v = interp(1'b1, 64'(g - n * longint'(ONE))) * 64'd5548278;
    if (n > 8) return 8'd255;
    if (n >= 0) v = v << n;
    else if (-n >= 63) return 8'd0;
    else v = v >> (-n);
    v = v >> (FRAC + 16);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [31:0] tone_pixel(input logic [63:0] px);
    return {tone_byte(px[63:48]), tone_byte(px[47:32]),
            tone_byte(px[31:16]), tone_byte(px[15:0])};
  endfunction

  // random half: mostly finite positives across all exponents, some raw noise
  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    if ($urandom_range(99) < 75) begin
      h[15]    = 1'b0;
      h[14:10] = 5'($urandom_range(30));
    end
    return h;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

  // ROM contents: log2(1+i/N) and 2^(i/N), worked out in Q30
  initial begin
    logic [63:0] root [TBITS+1];
    logic [63:0] z;
    logic [63:0] r;
    logic [63:0] ex;
    root[0] = 64'd2 << 30;
    for (int kk = 1; kk <= TBITS; kk++) root[kk] = int_sqrt(root[kk-1] << 30);
    for (int i = 0; i < TSIZE; i++) begin
      z  = (64'd1 << 30) + (64'(i) << (30 - TBITS));
      r  = '0;
      ex = 64'd1 << 30;
      for (int kk = 1; kk <= 30; kk++) begin
        z = (z * z) >> 30;
        if (z >= (64'd2 << 30)) begin
          z = z >> 1;
          r = r | (64'd1 << (30 - kk));
        end
      end
      for (int kk = 0; kk < TBITS; kk++)
        if (((i >> kk) & 1) != 0) ex = (ex * root[TBITS - kk]) >> 30;
      log_tab[i] = (r + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      exp_tab[i] = (ex + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    end
    log_tab[TSIZE] = ONE;
    exp_tab[TSIZE] = 2 * ONE;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) hold_left = 120;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // sender
  initial begin
    pixel_row_t rows [$];
    pixel_row_t row;
    row_tag_t   tg;
    int         total;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    rst       = 1'b1;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    stim_done = 1'b0;
    // alpha, blue, green, red from the top down
    rows = '{
      '{{16'h0000, 16'hFE00, 16'hFC00, 16'h7C00}, 1, {8'd0, 8'd0, 8'd0, 8'd255}},
      '{{16'h8001, 16'h8000, 16'hBC00, 16'hFBFF}, 1, 32'd0},
      '{{16'h7DFF, 16'h7C01, 16'hFFFF, 16'h7FFF}, 1, 32'd0},
      '{{16'h7C00, 16'h7C00, 16'h7C00, 16'h7C00}, 1, 32'hFFFF_FFFF},
      '{{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1, 32'd0},
      '{{16'h7BFF, 16'h7BFF, 16'h7BFF, 16'h7BFF}, 0, 32'd0},
      '{{16'h0001, 16'h0002, 16'h03FF, 16'h0400}, 0, 32'd0},
      '{{16'h3C00, 16'h3400, 16'h2E66, 16'h2E8E}, 0, 32'd0},
      '{{16'h3800, 16'h4000, 16'h4900, 16'h5640}, 0, 32'd0},
      '{{16'h1000, 16'h2000, 16'h2800, 16'h3000}, 0, 32'd0},
      '{{16'h6000, 16'h7000, 16'h7800, 16'h5C00}, 0, 32'd0},
      '{{16'h2E8F, 16'h2E8D, 16'h3555, 16'h3AAA}, 0, 32'd0}
    };
    for (int i = 0; i < NRAND; i++) begin
      row.pixel = {rand_half(), rand_half(), rand_half(), rand_half()};
      row.typed = 0;
      row.want  = '0;
      rows = {rows, row};
    end
    total = rows.size();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < total; i++) begin
      int r;
      r = i - 12;
      if (r == 0)          begin idle_pct = 0;  stall_pct = 0;  end
      if (r == NRAND / 4)  begin idle_pct = 47; stall_pct = 0;  end
      if (r == NRAND / 2)  begin idle_pct = 0;  stall_pct = 47; end
      if (r == 3 * NRAND / 4) begin idle_pct = 22; stall_pct = 22; end
      hold_req = (r == 40);
      while ($urandom_range(99) < idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      tg.typed = rows[i].typed;
      tg.want  = rows[i].want;
      tag_q = {tag_q, tg};
      s_tvalid <= 1'b1;
      s_tdata  <= rows[i].pixel;
      do @(posedge clk); while (!s_tready);
      @(negedge clk);
    end
    s_tvalid  <= 1'b0;
    hold_req  = 1'b0;
    stim_done = 1'b1;
  end

  // requests in, results out
  always @(posedge clk) begin
    row_tag_t    tag;
    logic [31:0] want;
    if (!rst && s_tvalid && s_tready) begin
      tag  = tag_q.pop_front();
      want = tag.typed ? tag.want : tone_pixel(s_tdata);
      byte_q = {byte_q, want};
    end
    if (!rst && m_tvalid && m_tready) begin
      if (byte_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected pixel %h", m_tdata);
      end else begin
        want = byte_q.pop_front();
        for (int c = 0; c < 4; c++)
          if (m_tdata[8*c +: 8] !== want[8*c +: 8]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: channel %0d expected %0d got %0d", c,
                       want[8*c +: 8], m_tdata[8*c +: 8]);
          end
      end
    end
  end

  initial begin
    mismatches = 0;
    wait (stim_done);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && byte_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
